/* hdl/ihpc_pkg.sv */
// Shared types, constants and coefficient tables for the high-pass cascade with mute.
// Used by the controller, the datapath, the mute stage and the top level.
package ihpc_pkg;

   // Defaults for the top-level parameters.
   localparam int SECTION_COUNT_DEFAULT = 7;
   localparam int TAPS_DEFAULT          = 3;
   localparam int COUNT_WIDTH_DEFAULT   = 20;

   // Fixed field and arithmetic widths.
   localparam int SAMPLE_W   = 16;
   localparam int SIG_W      = 40;
   localparam int FRAC_W     = 16;
   localparam int COEF_W     = 32;
   localparam int LEN_W      = 20;
   localparam int PROD_SHIFT = 15;
   localparam int MUL_SPLIT  = 20;
   localparam int ACC_W      = 60;
   localparam int SAMPLE_MAX = 32767;

   // Term slots of one section, in issue order.
   localparam int SLOT_W    = 3;
   localparam int SLOT_MAX  = 5;
   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_F1 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_F2 = 3'd4;

   // Coefficient sets repeat every six sections.
   localparam int SMOD_W    = 3;
   localparam int COEF_SETS = 6;

   // Feed-forward b0, b1, b2 in Q2.30.
   localparam logic signed [COEF_W-1:0] FF_COEF [COEF_SETS][3] = '{
      '{32'sd1032518327, 32'sd0, 32'sd0},
      '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824},
      '{32'sd977107564, 32'sd0, 32'sd0},
      '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824},
      '{32'sd1013946283, 32'sd0, 32'sd0},
      '{32'sd1073741824, -32'sd1073741824, 32'sd0}
   };

   // Feedback f1, f2 (negated a1, a2) in Q2.30; the first column is unused.
   localparam logic signed [COEF_W-1:0] FB_COEF [COEF_SETS][3] = '{
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd2057854818, -32'sd998476666},
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd1947418710, -32'sd887269722},
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd954150741, 32'sd0}
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;
      logic                 issue;
      logic                 write_back;
      logic [SLOT_W-1:0]    slot;
      logic [SMOD_W-1:0]    smod;
   } ihpc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
   } ihpc_status_type;

   // Result of the search for the next term to issue.
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } ihpc_pick_type;

   // Coefficient of one term slot of a coefficient set.
   function automatic logic signed [COEF_W-1:0] slot_coef(input logic [SMOD_W-1:0] smod,
                                                          input logic [SLOT_W-1:0] slot);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (smod < SMOD_W'(COEF_SETS)) begin
         case (slot)
            SLOT_B0: c = FF_COEF[smod][0];
            SLOT_B1: c = FF_COEF[smod][1];
            SLOT_F1: c = FB_COEF[smod][1];
            SLOT_B2: c = FF_COEF[smod][2];
            SLOT_F2: c = FB_COEF[smod][2];
            default: c = '0;
         endcase
      end
      return c;
   endfunction

   // History tap that a slot reads.
   function automatic logic [1:0] slot_tap(input logic [SLOT_W-1:0] slot);
      logic [1:0] t;
      case (slot)
         SLOT_B1, SLOT_F1: t = 2'd1;
         SLOT_B2, SLOT_F2: t = 2'd2;
         default:          t = 2'd0;
      endcase
      return t;
   endfunction

   // A feedback slot reads the section's own history, the others its source.
   function automatic logic slot_is_fb(input logic [SLOT_W-1:0] slot);
      return (slot == SLOT_F1) || (slot == SLOT_F2);
   endfunction

   // First slot at or after start that is in range and has a nonzero coefficient.
   function automatic ihpc_pick_type next_slot(input logic [SMOD_W-1:0] smod,
                                               input logic [SLOT_W-1:0] start,
                                               input logic [SLOT_W-1:0] limit);
      ihpc_pick_type pick;
      pick = '0;
      for (int k = SLOT_MAX - 1; k >= 0; k--) begin
         if (SLOT_W'(k) >= start && SLOT_W'(k) < limit &&
             slot_coef(smod, SLOT_W'(k)) != '0) begin
            pick.found = 1'b1;
            pick.slot  = SLOT_W'(k);
         end
      end
      return pick;
   endfunction

endpackage

/* hdl/ihpc_ctrl.sv */
// Sequencer for the filter cascade: walks sections and their nonzero terms.
// Depends on ihpc_pkg for command, status and slot search.
module ihpc_ctrl #(
   parameter int SECTION_COUNT    = ihpc_pkg::SECTION_COUNT_DEFAULT,
   parameter int TAPS_PER_SECTION = ihpc_pkg::TAPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  ihpc_pkg::ihpc_status_type          dp_status,
   input  logic                               out_free,
   output ihpc_pkg::ihpc_cmd_type             dp_cmd,
   output logic [$clog2(SECTION_COUNT)-1:0]   section,
   output logic                               finish
);
   import ihpc_pkg::*;

   localparam int SEC_W = $clog2(SECTION_COUNT);
   localparam logic [SEC_W-1:0]  LAST_SECTION = SEC_W'(SECTION_COUNT - 2);
   localparam logic [SLOT_W-1:0] SLOT_LIMIT   = SLOT_W'(2 * TAPS_PER_SECTION - 1);
   localparam logic [SMOD_W-1:0] LAST_SET     = SMOD_W'(COEF_SETS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ISSUE  = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_FINISH = 5'b10000
   } ihpc_state_type;

   ihpc_state_type     state_ff, state_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [SMOD_W-1:0]  smod_ff, smod_in, smod_next;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SMOD_W-1:0]  pick_smod;
   logic [SLOT_W-1:0]  pick_start;
   ihpc_pick_type      pick;

   // Coefficient set of the following section.
   assign smod_next = (smod_ff == LAST_SET) ? '0 : smod_ff + SMOD_W'(1);
   assign pick      = next_slot(pick_smod, pick_start, SLOT_LIMIT);

   // Next-state logic.
   always_comb begin
      state_in   = state_ff;
      sec_in     = sec_ff;
      smod_in    = smod_ff;
      slot_in    = slot_ff;
      pick_smod  = smod_ff;
      pick_start = slot_ff + SLOT_W'(1);
      case (state_ff)
         ST_IDLE: begin
            pick_smod  = '0;
            pick_start = '0;
            if (req_tvalid) begin
               sec_in   = '0;
               smod_in  = '0;
               slot_in  = pick.slot;
               state_in = pick.found ? ST_ISSUE : ST_DRAIN;
            end
         end
         ST_ISSUE: begin
            if (pick.found) begin
               slot_in = pick.slot;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_status.busy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            pick_smod  = smod_next;
            pick_start = '0;
            if (sec_ff == LAST_SECTION) begin
               state_in = ST_FINISH;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               smod_in  = smod_next;
               slot_in  = pick.slot;
               state_in = pick.found ? ST_ISSUE : ST_DRAIN;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sec_ff   <= '0;
         smod_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
         smod_ff  <= smod_in;
         slot_ff  <= slot_in;
      end
   end

   // Commands and handshake.
   assign req_tready        = (state_ff == ST_IDLE);
   assign dp_cmd.load       = (state_ff == ST_IDLE) && req_tvalid;
   assign dp_cmd.issue      = (state_ff == ST_ISSUE);
   assign dp_cmd.write_back = (state_ff == ST_WRITE);
   assign dp_cmd.slot       = slot_ff;
   assign dp_cmd.smod       = smod_ff;
   assign section           = sec_ff;
   assign finish            = (state_ff == ST_FINISH) && out_free;

`ifndef NO_ASSERTIONS
   // A new word never lands while terms are still in the multiply pipeline.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |-> !dp_status.busy)
      else $error("sample loaded while pipeline busy");

   // A section result is written only after its last term has been summed.
   a_write_drained: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.write_back |-> !dp_status.busy)
      else $error("section written before pipeline drained");

   // One word at a time: after an accept the input side closes.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice in a row");
`endif

endmodule

/* hdl/ihpc_datapath.sv */
// History memory and shared multiply-accumulate pipeline of the filter cascade.
// Depends on ihpc_pkg for the command and status structs and coefficient tables.
module ihpc_datapath #(
   parameter int SECTION_COUNT    = ihpc_pkg::SECTION_COUNT_DEFAULT,
   parameter int TAPS_PER_SECTION = ihpc_pkg::TAPS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ihpc_pkg::ihpc_cmd_type                  dp_cmd,
   input  logic [$clog2(SECTION_COUNT)-1:0]        section,
   input  logic signed [ihpc_pkg::SAMPLE_W-1:0]    sample,
   output ihpc_pkg::ihpc_status_type               dp_status,
   output logic signed [ihpc_pkg::SIG_W-1:0]       y
);
   import ihpc_pkg::*;

   localparam int SEC_W   = $clog2(SECTION_COUNT);
   localparam int RB      = $clog2(TAPS_PER_SECTION);
   localparam int AW      = SEC_W + RB;
   localparam int DEPTH   = SECTION_COUNT << RB;
   localparam int LO_W    = MUL_SPLIT + 1 + COEF_W;
   localparam int HI_W    = SIG_W - MUL_SPLIT + COEF_W;
   localparam int FULL_W  = SIG_W + COEF_W;
   localparam int PROD_W  = FULL_W - PROD_SHIFT;
   localparam int SHIFT_W = ACC_W - PROD_SHIFT;

   // Row 0 holds input history, row s+1 the outputs of section s, each a ring.
   logic [SIG_W-1:0]         mem [DEPTH];
   logic [DEPTH-1:0]         valid_ff;
   logic [RB-1:0]            ptr_ff;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [SIG_W-1:0]         wr_data;
   logic [SEC_W-1:0]         rd_row;
   logic [RB-1:0]            rd_pos;
   logic [1:0]               rd_tap;
   logic [AW-1:0]            rd_addr;

   logic [SIG_W-1:0]         rd_data_ff;
   logic                     rd_ok_ff;
   logic                     rd_v_ff;
   logic signed [COEF_W-1:0] coef_ff;

   logic signed [SIG_W-1:0]  x_op;
   logic signed [LO_W-1:0]   p_lo_in, p_lo_ff;
   logic signed [HI_W-1:0]   p_hi_in, p_hi_ff;
   logic                     mul_v_ff;

   logic signed [FULL_W-1:0] full;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_v_ff;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [SIG_W-1:0]  sec_out;
   logic signed [SIG_W-1:0]  y_ff;

   // Section output: floor to 16 fraction bits and saturate to 40 bits.
   assign shifted = acc_ff[ACC_W-1:PROD_SHIFT];
   always_comb begin
      if ((&shifted[SHIFT_W-1:SIG_W-1]) || !(|shifted[SHIFT_W-1:SIG_W-1])) begin
         sec_out = shifted[SIG_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         sec_out = {1'b1, {(SIG_W-1){1'b0}}};
      end else begin
         sec_out = {1'b0, {(SIG_W-1){1'b1}}};
      end
   end

   // Write port: new input sample or a finished section output.
   always_comb begin
      wr_en   = dp_cmd.load || dp_cmd.write_back;
      wr_addr = {SEC_W'(0), ptr_ff + RB'(1)};
      wr_data = {{(SIG_W-SAMPLE_W-FRAC_W){sample[SAMPLE_W-1]}}, sample, {FRAC_W{1'b0}}};
      if (dp_cmd.write_back) begin
         wr_addr = {section + SEC_W'(1), ptr_ff};
         wr_data = sec_out;
      end
   end

   // Read address of the term being issued.
   assign rd_tap  = slot_tap(dp_cmd.slot);
   assign rd_row  = slot_is_fb(dp_cmd.slot) ? section + SEC_W'(1) : section;
   assign rd_pos  = ptr_ff - rd_tap[RB-1:0];
   assign rd_addr = {rd_row, rd_pos};

   // History memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_ok_ff   <= valid_ff[rd_addr];
      coef_ff    <= slot_coef(dp_cmd.smod, dp_cmd.slot);
   end

   // Entry valid bits and ring pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (dp_cmd.load) begin
            ptr_ff <= ptr_ff + RB'(1);
         end
      end
   end

   // Split multiply: low 20 bits unsigned and high 20 bits signed.
   assign x_op    = rd_ok_ff ? $signed(rd_data_ff) : '0;
   assign p_lo_in = $signed({1'b0, x_op[MUL_SPLIT-1:0]}) * coef_ff;
   assign p_hi_in = $signed(x_op[SIG_W-1:MUL_SPLIT]) * coef_ff;

   // Recombine the partial products and floor to 31 fraction bits.
   assign full = $signed({p_hi_ff, {MUL_SPLIT{1'b0}}}) + FULL_W'(p_lo_ff);

   // Pipeline payload.
   always_ff @(posedge clock) begin
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      prod_ff <= full[FULL_W-1:PROD_SHIFT];
      if (dp_cmd.load || dp_cmd.write_back) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (dp_cmd.write_back) begin
         y_ff <= sec_out;
      end
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         mul_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= dp_cmd.issue;
         mul_v_ff  <= rd_v_ff;
         prod_v_ff <= mul_v_ff;
      end
   end

   assign dp_status.busy = rd_v_ff || mul_v_ff || prod_v_ff;
   assign y              = y_ff;

endmodule

/* hdl/ihpc_mute.sv */
// Frame mute counter, output clamp and result register of the cascade.
// Depends on ihpc_pkg for field widths and clamp limits.
module ihpc_mute #(
   parameter int COUNT_WIDTH = ihpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ihpc_pkg::LEN_W-1:0]            csr_wr_data,
   input  logic                                  load,
   input  logic                                  first_of_frame,
   input  logic                                  voice_start,
   input  logic                                  finish,
   input  logic signed [ihpc_pkg::SIG_W-1:0]     y,
   output logic                                  out_free,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ihpc_pkg::SAMPLE_W-1:0]         rsp_sample,
   output logic                                  rsp_muted
);
   import ihpc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
   localparam int Q_W   = SIG_W + 1 - FRAC_W;

   logic [LEN_W-1:0]        mute_len_ff;
   logic [COUNT_WIDTH-1:0]  count_ff, count_eff, count_in;
   logic                    frame_muted_ff, muted_now;
   logic                    first_ff, voice_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_W-1:0]     rsp_sample_ff;
   logic                    rsp_muted_ff;

   logic                    neg;
   logic signed [SIG_W:0]   y_ext, mag;
   logic [Q_W-1:0]          q;
   logic [SAMPLE_W-1:0]     qc, clamped;

   // Mute length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mute_len_ff <= '0;
      end else if (csr_wr_en) begin
         mute_len_ff <= csr_wr_data;
      end
   end

   // Frame flags of the word in flight.
   always_ff @(posedge clock) begin
      if (load) begin
         first_ff <= first_of_frame;
         voice_ff <= voice_start;
      end
   end

   // Mute decision at frame start, saturating count of muted words.
   always_comb begin
      count_eff = (first_ff && voice_ff) ? '0 : count_ff;
      muted_now = first_ff ? (CMP_W'(count_eff) < CMP_W'(mute_len_ff)) : frame_muted_ff;
      count_in  = count_eff;
      if (muted_now && count_eff != '1) begin
         count_in = count_eff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         frame_muted_ff <= 1'b0;
      end else if (finish) begin
         count_ff       <= count_in;
         frame_muted_ff <= muted_now;
      end
   end

   // Truncate toward zero to an integer and clamp to the symmetric range.
   always_comb begin
      y_ext   = (SIG_W+1)'(y);
      neg     = y[SIG_W-1];
      mag     = neg ? -y_ext : y_ext;
      q       = mag[SIG_W:FRAC_W];
      qc      = (q > Q_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : q[SAMPLE_W-1:0];
      clamped = neg ? -qc : qc;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_sample_ff <= muted_now ? '0 : clamped;
         rsp_muted_ff  <= muted_now;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_muted  = rsp_muted_ff;

`ifndef NO_ASSERTIONS
   // A finished word is presented on the next cycle.
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_tvalid)
      else $error("finished word not presented");

   // A muted word carries silence.
   a_muted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_muted) |-> (rsp_sample == '0))
      else $error("muted word is not silent");

   // A stalled output word stays put until it is taken.
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_sample) && $stable(rsp_muted)))
      else $error("stalled output word changed");
`endif

endmodule

/* hdl/iir_highpass_cascade_mute_unit.sv */
// High-pass cascade of gain, biquad and first-order sections with frame start-up mute.
// Top level: joins the controller, the datapath and the mute stage; uses ihpc_pkg.
//
// Input channel req_*: one audio word per handshake, accepted when req_tvalid and
// req_tready are both high. Output channel rsp_*: one filtered word per input word,
// in order. The csr_* port writes the mute length; write it only while idle.
//
// One word is in the filter at a time. Each section runs its nonzero terms through
// the single shared multiply-accumulate pipeline (one read of the history memory,
// two multiply stages, one accumulate), then drains it and writes the result back.
// With the default coefficients a word has 16 nonzero terms in all; the next word
// is accepted once the current one has finished.
// A finished word sits in the output register; a stalled receiver does not block
// the next accept, but the cascade holds its result until the register is free.
// Reset clears the filter history (by entry valid bits), the mute counter, the mute
// decision and the mute length, and leaves the block ready in the next cycle.
module iir_highpass_cascade_mute_unit #(
   parameter int SECTION_COUNT    = ihpc_pkg::SECTION_COUNT_DEFAULT,
   parameter int TAPS_PER_SECTION = ihpc_pkg::TAPS_DEFAULT,
   parameter int COUNT_WIDTH      = ihpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input word.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ihpc_pkg::SAMPLE_W-1:0]     req_tdata,   // [15:0] sample_in
   input  logic [1:0]                        req_tuser,   // [0] first_of_frame, [1] voice_start
   // Result word.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ihpc_pkg::SAMPLE_W-1:0]     rsp_tdata,   // [15:0] sample_out
   output logic                              rsp_tuser,   // [0] muted
   // Mute length register.
   input  logic                              csr_wr_en,
   input  logic [ihpc_pkg::LEN_W-1:0]        csr_wr_data
);
   import ihpc_pkg::*;

   ihpc_cmd_type                     dp_cmd;
   ihpc_status_type                  dp_status;
   logic [$clog2(SECTION_COUNT)-1:0] section;
   logic                             out_free;
   logic                             finish;
   logic signed [SIG_W-1:0]          y;

   // Sequencer.
   ihpc_ctrl #(
      .SECTION_COUNT    (SECTION_COUNT),
      .TAPS_PER_SECTION (TAPS_PER_SECTION)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .out_free   (out_free),
      .dp_cmd     (dp_cmd),
      .section    (section),
      .finish     (finish)
   );

   // History memory and multiply-accumulate.
   ihpc_datapath #(
      .SECTION_COUNT    (SECTION_COUNT),
      .TAPS_PER_SECTION (TAPS_PER_SECTION)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .section   (section),
      .sample    ($signed(req_tdata)),
      .dp_status (dp_status),
      .y         (y)
   );

   // Mute decision, clamp and result register.
   ihpc_mute #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_mute (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .load           (dp_cmd.load),
      .first_of_frame (req_tuser[0]),
      .voice_start    (req_tuser[1]),
      .finish         (finish),
      .y              (y),
      .out_free       (out_free),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_sample     (rsp_tdata),
      .rsp_muted      (rsp_tuser)
   );

endmodule
